@@ design/mvhe_pkg.sv @@
// Shared types and constants of the MessagePack value header encoder.
package mvhe_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned FRAME_W = VALUE_W + BYTE_W;
   localparam int unsigned CNT_W   = 4;

   typedef enum logic [3:0] {
      ACT_NIL   = 4'd0,
      ACT_MAP   = 4'd1,
      ACT_ARRAY = 4'd2,
      ACT_UINT  = 4'd3,
      ACT_SINT  = 4'd4,
      ACT_F32   = 4'd5,
      ACT_F64   = 4'd6,
      ACT_STR   = 4'd7,
      ACT_BIN   = 4'd8,
      ACT_RAW   = 4'd9
   } act_type;

   localparam logic [7:0] MK_NIL      = 8'hc0;
   localparam logic [7:0] MK_FIXMAP   = 8'h80;
   localparam logic [7:0] MK_MAP16    = 8'hde;
   localparam logic [7:0] MK_MAP32    = 8'hdf;
   localparam logic [7:0] MK_FIXARRAY = 8'h90;
   localparam logic [7:0] MK_ARRAY16  = 8'hdc;
   localparam logic [7:0] MK_ARRAY32  = 8'hdd;
   localparam logic [7:0] MK_UINT8    = 8'hcc;
   localparam logic [7:0] MK_UINT16   = 8'hcd;
   localparam logic [7:0] MK_UINT32   = 8'hce;
   localparam logic [7:0] MK_UINT64   = 8'hcf;
   localparam logic [7:0] MK_INT8     = 8'hd0;
   localparam logic [7:0] MK_INT16    = 8'hd1;
   localparam logic [7:0] MK_INT32    = 8'hd2;
   localparam logic [7:0] MK_INT64    = 8'hd3;
   localparam logic [7:0] MK_FLOAT32  = 8'hca;
   localparam logic [7:0] MK_FLOAT64  = 8'hcb;
   localparam logic [7:0] MK_FIXSTR   = 8'ha0;
   localparam logic [7:0] MK_STR8     = 8'hd9;
   localparam logic [7:0] MK_STR16    = 8'hda;
   localparam logic [7:0] MK_STR32    = 8'hdb;
   localparam logic [7:0] MK_BIN8     = 8'hc4;
   localparam logic [7:0] MK_BIN16    = 8'hc5;
   localparam logic [7:0] MK_BIN32    = 8'hc6;

   // One decoded item: the bytes to send, first byte at the top of the frame.
   typedef struct packed {
      logic                 emit;
      logic [CNT_W-1:0]     count;
      logic [FRAME_W-1:0]   frame;
   } dec_type;

endpackage

@@ design/mvhe_decode.sv @@
// Form selection and byte frame assembly for one encoder item.
module mvhe_decode (
   input  mvhe_pkg::act_type         act,
   input  logic [63:0]               value,
   output mvhe_pkg::dec_type         dec
);
   import mvhe_pkg::*;

   logic [31:0] len;
   logic [7:0]  marker;
   logic [3:0]  nbytes;
   logic        emit;

   assign len = value[31:0];

   always_comb begin
      marker = MK_NIL;
      nbytes = 4'd0;
      emit   = 1'b1;
      case (act)
         ACT_NIL: begin
            marker = MK_NIL;
         end
         ACT_MAP: begin
            if (len[31:4] == '0) begin
               marker = MK_FIXMAP | {4'h0, len[3:0]};
            end else if (len[31:16] == '0) begin
               marker = MK_MAP16;
               nbytes = 4'd2;
            end else begin
               marker = MK_MAP32;
               nbytes = 4'd4;
            end
         end
         ACT_ARRAY: begin
            if (len[31:4] == '0) begin
               marker = MK_FIXARRAY | {4'h0, len[3:0]};
            end else if (len[31:16] == '0) begin
               marker = MK_ARRAY16;
               nbytes = 4'd2;
            end else begin
               marker = MK_ARRAY32;
               nbytes = 4'd4;
            end
         end
         ACT_UINT, ACT_SINT: begin
            if (act == ACT_SINT && value[63]) begin
               if (&value[63:7]) begin
                  marker = MK_INT8;
                  nbytes = 4'd1;
               end else if (&value[63:15]) begin
                  marker = MK_INT16;
                  nbytes = 4'd2;
               end else if (&value[63:31]) begin
                  marker = MK_INT32;
                  nbytes = 4'd4;
               end else begin
                  marker = MK_INT64;
                  nbytes = 4'd8;
               end
            end else if (value[63:8] == '0) begin
               marker = MK_UINT8;
               nbytes = 4'd1;
            end else if (value[63:16] == '0) begin
               marker = MK_UINT16;
               nbytes = 4'd2;
            end else if (value[63:32] == '0) begin
               marker = MK_UINT32;
               nbytes = 4'd4;
            end else begin
               marker = MK_UINT64;
               nbytes = 4'd8;
            end
         end
         ACT_F32: begin
            marker = MK_FLOAT32;
            nbytes = 4'd4;
         end
         ACT_F64: begin
            marker = MK_FLOAT64;
            nbytes = 4'd8;
         end
         ACT_STR: begin
            if (len[31:5] == '0) begin
               marker = MK_FIXSTR | {3'b000, len[4:0]};
            end else if (len[31:8] == '0) begin
               marker = MK_STR8;
               nbytes = 4'd1;
            end else if (len[31:16] == '0) begin
               marker = MK_STR16;
               nbytes = 4'd2;
            end else begin
               marker = MK_STR32;
               nbytes = 4'd4;
            end
         end
         ACT_BIN: begin
            if (len[31:8] == '0) begin
               marker = MK_BIN8;
               nbytes = 4'd1;
            end else if (len[31:16] == '0) begin
               marker = MK_BIN16;
               nbytes = 4'd2;
            end else begin
               marker = MK_BIN32;
               nbytes = 4'd4;
            end
         end
         ACT_RAW: begin
            marker = value[7:0];
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // The operand bytes follow the marker, most significant first.
   always_comb begin
      dec.emit  = emit;
      dec.count = emit ? (nbytes + 4'd1) : '0;
      case (nbytes)
         4'd1:    dec.frame = {marker, value[7:0],  56'h0};
         4'd2:    dec.frame = {marker, value[15:0], 48'h0};
         4'd4:    dec.frame = {marker, value[31:0], 32'h0};
         4'd8:    dec.frame = {marker, value};
         default: dec.frame = {marker, 64'h0};
      endcase
   end

endmodule

@@ design/msgpack_value_header_encoder.sv @@
// Top level of the MessagePack value header encoder: input register, decode and byte serialiser.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_stall  | req_action[3:0], req_value[63:0]
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte[7:0], rsp_last
//
// An item accepted on req is held in an input register, decoded in the following cycle
// and loaded into the serialiser once that can take it; the serialiser's top byte is the
// rsp register, so the first byte is offered from it after the input register.
// An item produces one to nine bytes at one byte per cycle while rsp is not stalled, so
// it occupies the single byte output lane until its final byte; items with an unused
// action code produce no byte and leave the input register without being loaded.
// The next item is loaded while the final byte of the previous one is transferred, so
// single-byte items flow at one per cycle while rsp is not stalled.
// Reset clears the input valid flag and the serialiser byte count only.
// A stall on rsp holds the current byte; once the input register is also full, req is
// stalled until the serialiser can take its item.
module msgpack_value_header_encoder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_action,
   input  logic [63:0] req_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);
   import mvhe_pkg::*;

   // Input register.
   logic               in_vld_ff, in_vld_in;
   act_type            in_act_ff;
   logic [63:0]        in_value_ff;

   // Serialiser: remaining byte count and the bytes still to send, next at the top.
   logic [CNT_W-1:0]   ser_cnt_ff, ser_cnt_in;
   logic [FRAME_W-1:0] ser_frame_ff, ser_frame_in;

   dec_type            dec;
   logic               req_xfer;
   logic               ser_free;
   logic               load_ser;
   logic               consume_in;

   mvhe_decode u_decode (
      .act   (in_act_ff),
      .value (in_value_ff),
      .dec   (dec)
   );

   // The serialiser can take a new item when it is empty, or when its final byte
   // is being transferred in this cycle.
   assign ser_free   = (ser_cnt_ff == '0) || ((ser_cnt_ff == CNT_W'(1)) && !rsp_stall);
   assign load_ser   = in_vld_ff && dec.emit && ser_free;
   assign consume_in = in_vld_ff && (!dec.emit || ser_free);
   assign req_stall  = in_vld_ff && !consume_in;
   assign req_xfer   = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_xfer) begin
         in_vld_in = 1'b1;
      end else if (consume_in) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      ser_cnt_in   = ser_cnt_ff;
      ser_frame_in = ser_frame_ff;
      if (load_ser) begin
         ser_cnt_in   = dec.count;
         ser_frame_in = dec.frame;
      end else if ((ser_cnt_ff != '0) && !rsp_stall) begin
         ser_cnt_in   = ser_cnt_ff - CNT_W'(1);
         ser_frame_in = {ser_frame_ff[FRAME_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         ser_cnt_ff <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         ser_cnt_ff <= ser_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_act_ff   <= act_type'(req_action);
         in_value_ff <= req_value;
      end
      ser_frame_ff <= ser_frame_in;
   end

   assign rsp_valid    = (ser_cnt_ff != '0);
   assign rsp_out_byte = ser_frame_ff[FRAME_W-1 -: BYTE_W];
   assign rsp_last     = (ser_cnt_ff == CNT_W'(1));

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      ser_cnt_ff <= CNT_W'(9))
      else $error("serialiser byte count out of range");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_ser |=> rsp_valid)
      else $error("loaded item did not reach the output");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (!in_vld_ff || consume_in))
      else $error("input register overwritten before it was consumed");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("item bytes interrupted before the final byte");
`endif

endmodule

@@ tb/msgpack_stream_checker.sv @@
// Checker that predicts the MessagePack byte stream from req transfers and compares rsp transfers.
module msgpack_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [3:0]  req_action,
   input  logic [63:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last,
   output int          failures,
   output int          pending
);
   import mvhe_pkg::*;

   typedef struct packed {
      logic [3:0]  len;
      logic [71:0] seq;
   } encoding_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } stream_byte_type;

   stream_byte_type expected_bytes[$];

   // A marker followed by the low nbytes of v, most significant first, left aligned in seq.
   function automatic encoding_type with_marker(input logic [7:0] marker, input logic [63:0] v,
                                                input int unsigned nbytes);
      encoding_type e;
      e.len = 4'(nbytes + 1);
      e.seq = {marker, v << (64 - 8 * nbytes)};
      return e;
   endfunction

   function automatic encoding_type encode_uint(input logic [63:0] v);
      if (v <= 64'hff)
         return with_marker(MK_UINT8, v, 1);
      else if (v <= 64'hffff)
         return with_marker(MK_UINT16, v, 2);
      else if (v <= 64'hffff_ffff)
         return with_marker(MK_UINT32, v, 4);
      return with_marker(MK_UINT64, v, 8);
   endfunction

   function automatic encoding_type encode_sint(input logic [63:0] v);
      if (!v[63])
         return encode_uint(v);
      else if (v >= 64'hffff_ffff_ffff_ff80)
         return with_marker(MK_INT8, v, 1);
      else if (v >= 64'hffff_ffff_ffff_8000)
         return with_marker(MK_INT16, v, 2);
      else if (v >= 64'hffff_ffff_8000_0000)
         return with_marker(MK_INT32, v, 4);
      return with_marker(MK_INT64, v, 8);
   endfunction

   function automatic encoding_type encode_container(input logic [63:0] n, input logic [7:0] fix,
                                                     input logic [7:0] m16, input logic [7:0] m32);
      if (n <= 64'hf)
         return with_marker(fix | n[7:0], '0, 0);
      else if (n <= 64'hffff)
         return with_marker(m16, n, 2);
      return with_marker(m32, n, 4);
   endfunction

   function automatic encoding_type encode_item(input logic [3:0] act, input logic [63:0] v);
      logic [63:0]  n;
      encoding_type e;
      n = {32'h0, v[31:0]};
      e = '0;
      case (act)
         ACT_NIL:   e = with_marker(MK_NIL, '0, 0);
         ACT_MAP:   e = encode_container(n, MK_FIXMAP, MK_MAP16, MK_MAP32);
         ACT_ARRAY: e = encode_container(n, MK_FIXARRAY, MK_ARRAY16, MK_ARRAY32);
         ACT_UINT:  e = encode_uint(v);
         ACT_SINT:  e = encode_sint(v);
         ACT_F32:   e = with_marker(MK_FLOAT32, n, 4);
         ACT_F64:   e = with_marker(MK_FLOAT64, v, 8);
         ACT_STR: begin
            if (n <= 64'h1f)
               e = with_marker(MK_FIXSTR | n[7:0], '0, 0);
            else if (n <= 64'hff)
               e = with_marker(MK_STR8, n, 1);
            else if (n <= 64'hffff)
               e = with_marker(MK_STR16, n, 2);
            else
               e = with_marker(MK_STR32, n, 4);
         end
         ACT_BIN: begin
            if (n <= 64'hff)
               e = with_marker(MK_BIN8, n, 1);
            else if (n <= 64'hffff)
               e = with_marker(MK_BIN16, n, 2);
            else
               e = with_marker(MK_BIN32, n, 4);
         end
         ACT_RAW:   e = with_marker(v[7:0], '0, 0);
         default:   e = '0;
      endcase
      return e;
   endfunction

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      failures++;
      if (failures <= 10)
         $display("mismatch in %s: expected %h, got %h", field, want, got);
   endtask

   always @(posedge clock) begin
      stream_byte_type want;
      encoding_type    enc;
      if (reset) begin
         failures = 0;
         pending  = 0;
         expected_bytes.delete();
      end else begin
         // Check the rsp transfer first; a byte of a newly accepted item cannot be offered yet.
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               note_mismatch("unexpected byte", '0, {55'h0, rsp_out_byte, rsp_last});
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  note_mismatch("out_byte", 64'(want.out_byte), 64'(rsp_out_byte));
               if (rsp_last !== want.last)
                  note_mismatch("last", 64'(want.last), 64'(rsp_last));
            end
         end
         if (req_valid && !req_stall) begin
            enc = encode_item(req_action, req_value);
            for (int i = 0; i < int'(enc.len); i++)
               expected_bytes.push_back({enc.seq[71 - 8 * i -: 8], i == int'(enc.len) - 1});
         end
         pending = expected_bytes.size();
      end
   end

endmodule

@@ tb/testbench.sv @@
// Top of the encoder testbench: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;
   import mvhe_pkg::*;

   // Action codes that the encoder ignores; they must produce no byte at all.
   localparam logic [3:0] ACT_SPARE_FIRST = 4'd10;
   localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;

   localparam int RANDOM_ITEMS_PER_PHASE = 65;
   localparam int CYCLE_LIMIT            = 200000;
   // The first byte appears after the input and serialiser registers; this leaves ample margin.
   localparam int SETTLE_CYCLES          = 20;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_action;
   logic [63:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   int          failures;
   int          pending;
   int          cycle_count = 0;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   msgpack_value_header_encoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   msgpack_stream_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .failures     (failures),
      .pending      (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run is bounded by a cycle count, so a hung handshake ends as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The receiver decides afresh at every falling edge whether to hold off the next transfer.
   // The stall does not look at rsp_valid, so it lands on every byte position of an item.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Offers one item, possibly after a random idle gap, and returns at the falling edge
   // that follows its transfer. The payload stays put for as long as req_stall is high.
   task automatic send_item(input logic [3:0] act, input logic [63:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Withdraws valid and waits until every predicted byte has been transferred.
   // The extra falling edge keeps the lowering of valid in a time step of its own.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
   endtask

   // Values are drawn so that every size class of every form is reached, including the
   // boundaries either side of each form and lengths with rubbish in the upper word.
   function automatic logic [63:0] rand_value();
      logic [63:0] r;
      int unsigned k;
      r = {$urandom, $urandom};
      case ($urandom_range(4))
         0: r = r >> $urandom_range(63);
         1: r = ~(r >> $urandom_range(63));
         2: begin
            case ($urandom_range(8))
               0: k = 4;
               1: k = 5;
               2: k = 7;
               3: k = 8;
               4: k = 15;
               5: k = 16;
               6: k = 31;
               7: k = 32;
               default: k = 63;
            endcase
            r = (64'd1 << k) - 64'd2 + 64'($urandom_range(3));
            if ($urandom_range(1) == 0)
               r = ~r;
         end
         3: r = {r[63:32], r[31:0] >> $urandom_range(31)};
         default: ;
      endcase
      return r;
   endfunction

   // Sends items until the given number of meaningful ones has been transferred.
   // Ignored action codes are mixed in now and then but are not counted.
   task automatic run_random(input int count);
      int          done;
      logic [3:0]  act;
      done = 0;
      while (done < count) begin
         if ($urandom_range(15) == 0) begin
            act = 4'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
         end else begin
            act = 4'($urandom_range(ACT_NIL, ACT_RAW));
            done++;
         end
         send_item(act, rand_value());
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_NIL;
      req_value      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items, sent back to back with no idle gaps and no receiver stalls.
      send_item(ACT_NIL,   64'h0);
      send_item(ACT_MAP,   64'hf);
      send_item(ACT_MAP,   64'h10);
      // Only the low word is a length; the upper word must be ignored.
      send_item(ACT_MAP,   64'hffff_ffff_0001_0000);
      send_item(ACT_ARRAY, 64'hffff);
      send_item(ACT_ARRAY, 64'h0000_0000_ffff_ffff);
      send_item(ACT_UINT,  64'hff);
      send_item(ACT_UINT,  64'h100);
      send_item(ACT_UINT,  64'hffff_ffff);
      send_item(ACT_UINT,  64'hffff_ffff_ffff_ffff);
      // The largest positive signed value falls back to the unsigned forms.
      send_item(ACT_SINT,  64'h7fff_ffff_ffff_ffff);
      send_item(ACT_SINT,  64'hffff_ffff_ffff_ff80);
      send_item(ACT_SINT,  64'hffff_ffff_ffff_ff7f);
      send_item(ACT_SINT,  64'hffff_ffff_ffff_7fff);
      send_item(ACT_SINT,  64'hffff_ffff_8000_0000);
      send_item(ACT_SINT,  64'h8000_0000_0000_0000);
      // A single precision operand with the unused upper word set.
      send_item(ACT_F32,   64'hdead_beef_3f80_0000);
      send_item(ACT_F64,   64'h0123_4567_89ab_cdef);
      send_item(ACT_STR,   64'hffff_ffff_0000_001f);
      send_item(ACT_STR,   64'h20);
      send_item(ACT_STR,   64'h1_0000);
      send_item(ACT_BIN,   64'hff);
      send_item(ACT_BIN,   64'h1_0000);
      send_item(ACT_RAW,   64'hffff_ffff_ffff_ffa5);
      send_item(ACT_SPARE_FIRST, 64'hffff_ffff_ffff_ffff);
      send_item(ACT_SPARE_LAST,  64'h0);
      send_item(ACT_RAW,   64'h0);
      wait_drained();

      // Random phases: free flow, then idling sender, then stalling receiver, then both.
      // Each phase is drained completely before the next, so the sender also pauses
      // until every expected byte has arrived.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         run_random(RANDOM_ITEMS_PER_PHASE);
         wait_drained();
      end

      // Any stray byte after the last expected one would show up as a failure here.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
design/mvhe_pkg.sv
design/mvhe_decode.sv
design/msgpack_value_header_encoder.sv
tb/msgpack_stream_checker.sv
tb/testbench.sv
